### rtl/prpk_pkg.sv
// Shared types and constants for the pixel row packer.
`timescale 1ns / 1ps
`default_nettype none
package prpk_pkg;

  // Field widths fixed by the interface
  localparam int unsigned PixelBitsW = 32;
  localparam int unsigned WordW      = 32;
  localparam int unsigned BankW      = 4;
  localparam int unsigned WordIdxW   = 13;
  localparam int unsigned CountW     = 10;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 10;

  localparam int unsigned RegionWordsDefault = 7744;
  localparam int unsigned RegionW            = 14;

  localparam logic [WordW-1:0]    SignFlip   = 32'h8080_8080;
  localparam logic [7:0]          PatternRed = 8'd133;
  localparam logic [7:0]          Rgb565RMask = 8'hF8;
  localparam logic [7:0]          Rgb565GMask = 8'hE0;
  localparam logic [WordIdxW-1:0] PtrMax     = '1;
  localparam logic [CountW-1:0]   WidthReset = 10'd352;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPixelFormat = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 4'd1;

  typedef enum logic [1:0] {
    FMT_RGB888  = 2'd0,
    FMT_RGB565  = 2'd1,
    FMT_PATTERN = 2'd2
  } pixel_format_e;

  typedef struct packed {
    logic [PixelBitsW-1:0] pixel_bits;
    logic                  frame_start;
  } pixel_t;

  typedef struct packed {
    logic [BankW-1:0]    bank_index;
    logic [WordIdxW-1:0] word_index;
    logic [WordW-1:0]    write_word;
    logic                out_of_range;
  } result_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage
`default_nettype wire

### rtl/prpk_decode.sv
// Pixel decoder: turns one pixel word into red, green and blue bytes.
`timescale 1ns / 1ps
`default_nettype none
module prpk_decode (
  input  var prpk_pkg::pixel_format_e           pixel_format_i,
  input  var logic [prpk_pkg::PixelBitsW-1:0]   pixel_bits_i,
  input  var logic [prpk_pkg::CountW-1:0]       column_i,
  input  var logic [prpk_pkg::CountW-1:0]       row_i,
  output prpk_pkg::rgb_t                        rgb_o
);
  import prpk_pkg::*;

  logic [7:0] byte0;
  logic [7:0] byte1;

  assign byte0 = pixel_bits_i[7:0];
  assign byte1 = pixel_bits_i[15:8];

  // Select channel bytes by format; the unused code falls back to RGB888
  always_comb begin
    case (pixel_format_i)
      FMT_PATTERN: begin
        rgb_o.red   = PatternRed;
        rgb_o.green = column_i[8:1];
        rgb_o.blue  = row_i[8:1];
      end
      FMT_RGB565: begin
        rgb_o.red   = byte0 & Rgb565RMask;
        rgb_o.green = {byte0[2:0], 5'b0} | {3'b0, byte1[7:5], 2'b0};
        rgb_o.blue  = {byte1[4:0], 3'b0};
      end
      default: begin
        rgb_o.red   = pixel_bits_i[7:0];
        rgb_o.green = pixel_bits_i[15:8];
        rgb_o.blue  = pixel_bits_i[23:16];
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/prpk_packer.sv
// Byte packer with row/column counters and per-row-group word pointers.
`timescale 1ns / 1ps
`default_nettype none
module prpk_packer #(
  parameter int unsigned REGION_WORDS = prpk_pkg::RegionWordsDefault
) (
  input  var logic                            clk_i,
  input  var logic                            rst_ni,
  input  var logic                            fire_i,
  input  var logic                            frame_start_i,
  input  var prpk_pkg::rgb_t                  rgb_i,
  input  var logic [prpk_pkg::CountW-1:0]     image_width_i,
  output logic [prpk_pkg::CountW-1:0]         column_o,
  output logic [prpk_pkg::CountW-1:0]         row_o,
  output logic                                produced_o,
  output prpk_pkg::result_t                   result_o
);
  import prpk_pkg::*;

  localparam logic [RegionW-1:0] RegionLimit = RegionW'(REGION_WORDS);

  logic [CountW-1:0]   col_q, col_d;
  logic [CountW-1:0]   row_q, row_d;
  logic [23:0]         pend_q, pend_d;
  logic [WordIdxW-1:0] ptr_q [4];
  logic [WordIdxW-1:0] ptr_d [4];

  logic [23:0]         pend_e;
  logic [1:0]          phase;
  logic [1:0]          group;
  logic [WordIdxW-1:0] ptr;
  logic [WordW-1:0]    word;
  logic [BankW-1:0]    group_base;
  logic [CountW:0]     col_next;

  // Apply frame start ahead of this pixel
  assign column_o = frame_start_i ? '0 : col_q;
  assign row_o    = frame_start_i ? '0 : row_q;
  assign pend_e   = frame_start_i ? '0 : pend_q;
  assign phase    = column_o[1:0];
  assign group    = row_o[1:0];
  assign ptr      = frame_start_i ? '0 : ptr_q[group];

  // Assemble the word for this column phase
  always_comb begin
    word = '0;
    case (phase)
      2'd1: word = {rgb_i.red, pend_e[23:0]};
      2'd2: word = {rgb_i.green, rgb_i.red, pend_e[15:0]};
      2'd3: word = {rgb_i.blue, rgb_i.green, rgb_i.red, pend_e[7:0]};
      default: word = '0;
    endcase
  end

  assign produced_o = (phase != 2'd0);
  assign group_base = {1'b0, group, 1'b0} + {2'b0, group};

  assign result_o.bank_index   = group_base + {2'b0, phase} - BankW'(1);
  assign result_o.word_index   = ptr;
  assign result_o.write_word   = word ^ SignFlip;
  assign result_o.out_of_range = ({1'b0, ptr} >= RegionLimit);

  // Next pending bytes, pointers and counters
  assign col_next = {1'b0, column_o} + (CountW+1)'(1);

  always_comb begin
    case (phase)
      2'd0: pend_d = {rgb_i.blue, rgb_i.green, rgb_i.red};
      2'd1: pend_d = {8'h00, rgb_i.blue, rgb_i.green};
      2'd2: pend_d = {16'h0000, rgb_i.blue};
      default: pend_d = '0;
    endcase

    for (int g = 0; g < 4; g++) begin
      ptr_d[g] = frame_start_i ? '0 : ptr_q[g];
    end
    if (phase == 2'd3 && ptr != PtrMax) begin
      ptr_d[group] = ptr + WordIdxW'(1);
    end

    if (col_next >= {1'b0, image_width_i}) begin
      col_d = '0;
      row_d = row_o + CountW'(1);
    end else begin
      col_d = col_next[CountW-1:0];
      row_d = row_o;
    end
  end

  // Advance state on each consumed pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
      for (int g = 0; g < 4; g++) begin
        ptr_q[g] <= '0;
      end
    end else if (fire_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
      for (int g = 0; g < 4; g++) begin
        ptr_q[g] <= ptr_d[g];
      end
    end
  end

endmodule
`default_nettype wire

### rtl/pixel_row_packer_to_cnn_banks_core.sv
// Top level of the pixel row packer: handshakes, configuration and pipeline registers.
`timescale 1ns / 1ps
`default_nettype none
// Takes one camera pixel per transaction and emits 32-bit bank writes of four
// signed bytes: every four pixels of a row give three words, routed to bank
// 3 * (row mod 4) + word phase at the row group's word pointer. One pixel is
// taken per clock in steady state unless the output stalls; a pixel passes an
// input register and then a result register before its result is presented.
// The first pixel of each four-pixel group produces no write. Words past
// REGION_WORDS come out flagged with out_of_range and must not be written.
// Configuration writes are always accepted and should be issued while idle.
module pixel_row_packer_to_cnn_banks_core #(
  parameter int unsigned REGION_WORDS = prpk_pkg::RegionWordsDefault
) (
  input  var logic                           clk_i,
  input  var logic                           rst_ni,
  input  var logic                           in_valid_i,
  output logic                               in_stall_o,
  input  var prpk_pkg::pixel_t               in_data_i,
  output logic                               out_valid_o,
  input  var logic                           out_stall_i,
  output prpk_pkg::result_t                  out_data_o,
  input  var logic                           cfg_valid_i,
  output logic                               cfg_ready_o,
  input  var logic [prpk_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  var logic [prpk_pkg::CfgDataW-1:0]  cfg_data_i
);
  import prpk_pkg::*;

  pixel_format_e     fmt_q;
  logic [CountW-1:0] width_q;

  logic     in_valid_q;
  pixel_t   in_data_q;
  logic     out_valid_q;
  result_t  out_data_q;

  logic              out_free;
  logic              fire;
  logic              produced;
  result_t           result;
  rgb_t              rgb;
  logic [CountW-1:0] column;
  logic [CountW-1:0] row;

  assign cfg_ready_o = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FMT_RGB888;
      width_q <= WidthReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgPixelFormat) begin
        fmt_q <= pixel_format_e'(cfg_data_i[1:0]);
      end else if (cfg_index_i == CfgImageWidth) begin
        width_q <= cfg_data_i[CountW-1:0];
      end
    end
  end

  // Consume the staged pixel when its result has somewhere to go or it produces no result
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && (out_free || !produced);
  assign in_stall_o = in_valid_q && !fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  prpk_decode u_decode (
    .pixel_format_i (fmt_q),
    .pixel_bits_i   (in_data_q.pixel_bits),
    .column_i       (column),
    .row_i          (row),
    .rgb_o          (rgb)
  );

  prpk_packer #(
    .REGION_WORDS (REGION_WORDS)
  ) u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .frame_start_i (in_data_q.frame_start),
    .rgb_i         (rgb),
    .image_width_i (width_q),
    .column_o      (column),
    .row_o         (row),
    .produced_o    (produced),
    .result_o      (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && produced;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && fire && produced) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire
